@@ rtl/core/fwwt_pkg.sv @@
// Package of shared types and codes for the futex wait/wake table.
`default_nettype none
package fwwt_pkg;

	localparam logic [1:0] CMD_WAIT = 2'd0;
	localparam logic [1:0] CMD_WAKE = 2'd1;

	localparam int STATUS_WIDTH = 3;
	localparam int TOTAL_WIDTH = 7;
	localparam int VALUE_WIDTH = 32;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_BLOCKED = 3'd0,
		ST_FAULT = 3'd1,
		ST_AGAIN = 3'd2,
		ST_NO_SPACE = 3'd3,
		ST_UNSUPPORTED = 3'd4,
		ST_WAKE_DONE = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_SCAN,
		SQ_FINISH
	} seq_state_t;

endpackage
`default_nettype wire

@@ rtl/core/fwwt_table.sv @@
// Slot table memory: one write port and one registered read port.
`default_nettype none
module fwwt_table #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 57
) (
	input wire logic clk,
	input wire logic rd_en,
	input wire logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic [WIDTH-1:0] rd_data,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH)-1:0] wr_idx,
	input wire logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_idx];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/futex_wait_wake_table_unit.sv @@
// Top level of the futex wait/wake table: request sequencer, slot scan and result register.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------------
//  in      | in_valid, in_stall  | command, address, argument_value, loaded_value,
//          |                     | load_fault, task_id
//  out     | out_valid, out_stall| status, woken_task, woken_valid, woken_total, last
//
// One request is taken at a time. A fault, again, unsupported, zero-count or negative-count
// request skips the scan and goes straight to the finish state; a wait or wake scan reads
// one slot per cycle through the table's single read port while the output does not hold it.
// After reset a clearing pass over every slot empties the table; in_stall is high
// meanwhile. A stalled output holds the scan only when a woken task is waiting to go out.
`default_nettype none
module futex_wait_wake_table_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int TASK_ID_WIDTH = 8,
	parameter int ADDRESS_WIDTH = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] command,
	input wire logic [ADDRESS_WIDTH-1:0] address,
	input wire logic [fwwt_pkg::VALUE_WIDTH-1:0] argument_value,
	input wire logic [fwwt_pkg::VALUE_WIDTH-1:0] loaded_value,
	input wire logic load_fault,
	input wire logic [TASK_ID_WIDTH-1:0] task_id,
	output logic out_valid,
	input wire logic out_stall,
	output logic [fwwt_pkg::STATUS_WIDTH-1:0] status,
	output logic [TASK_ID_WIDTH-1:0] woken_task,
	output logic woken_valid,
	output logic [fwwt_pkg::TOTAL_WIDTH-1:0] woken_total,
	output logic last
);
	import fwwt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W = 1 + TASK_ID_WIDTH + ADDRESS_WIDTH;
	localparam logic [IDX_W:0] DEPTH_I = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	seq_state_t state_q, state_d;

	// Request held for the scan.
	logic is_wake_q;
	logic [ADDRESS_WIDTH-1:0] addr_q;
	logic [TASK_ID_WIDTH-1:0] task_q;
	logic [VALUE_WIDTH-1:0] limit_q;
	status_t res_status_q;

	logic [IDX_W-1:0] clr_idx_q;
	logic [IDX_W:0] issue_idx_q;
	logic chk_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;

	// A woken task whose result waits until it is known whether it is the last one.
	logic pend_valid_q;
	logic [TASK_ID_WIDTH-1:0] pend_task_q;

	logic out_valid_q;
	status_t out_status_q;
	logic [TASK_ID_WIDTH-1:0] out_task_q;
	logic out_wvalid_q;
	logic [TOTAL_WIDTH-1:0] out_total_q;
	logic out_last_q;

	logic [ENTRY_W-1:0] rd_data;
	logic entry_busy;
	logic [TASK_ID_WIDTH-1:0] entry_task;
	logic [ADDRESS_WIDTH-1:0] entry_addr;

	logic accept, out_free, hold, scan_go, issue;
	logic hit_free, hit_wake, scan_end, limit_hit;
	logic load_mid, load_fin;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [ENTRY_W-1:0] wr_data;

	fwwt_table #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_table (
		.clk(clk),
		.rd_en(issue),
		.rd_idx(issue_idx_q[IDX_W-1:0]),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data)
	);

	assign entry_busy = rd_data[ENTRY_W-1];
	assign entry_task = rd_data[ENTRY_W-2 -: TASK_ID_WIDTH];
	assign entry_addr = rd_data[ADDRESS_WIDTH-1:0];
	assign cnt_next = cnt_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = (state_q != SQ_IDLE);
		accept = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		hold = (state_q == SQ_SCAN) && pend_valid_q && !out_free;
		scan_go = (state_q == SQ_SCAN) && !hold;
		issue = scan_go && (issue_idx_q != DEPTH_I);
		hit_free = scan_go && chk_s1 && !is_wake_q && !entry_busy;
		hit_wake = scan_go && chk_s1 && is_wake_q && entry_busy && (entry_addr == addr_q);
		scan_end = scan_go && !chk_s1 && (issue_idx_q == DEPTH_I);
		limit_hit = (VALUE_WIDTH'(cnt_next) == limit_q);
		load_mid = hit_wake && pend_valid_q;
		load_fin = (state_q == SQ_FINISH) && out_free;
		wr_en = 1'b0;
		wr_idx = chk_idx_s1;
		wr_data = '0;
		case (state_q)
			SQ_CLEAR: begin
				wr_en = 1'b1;
				wr_idx = clr_idx_q;
				if (clr_idx_q == LAST_IDX) begin
					state_d = SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				if (accept) begin
					state_d = SQ_FINISH;
					if (command == CMD_WAIT && !load_fault && loaded_value == argument_value) begin
						state_d = SQ_SCAN;
					end else if (command == CMD_WAKE && !argument_value[VALUE_WIDTH-1]
							&& argument_value != '0) begin
						state_d = SQ_SCAN;
					end
				end
			end
			SQ_SCAN: begin
				if (hit_free) begin
					wr_en = 1'b1;
					wr_data = {1'b1, task_q, addr_q};
				end else if (hit_wake) begin
					wr_en = 1'b1;
				end
				if (hit_free || (hit_wake && limit_hit) || scan_end) begin
					state_d = SQ_FINISH;
				end
			end
			SQ_FINISH: begin
				if (out_free) begin
					state_d = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_CLEAR;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			issue_idx_q <= '0;
			chk_s1 <= 1'b0;
			cnt_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == SQ_CLEAR) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (accept) begin
				issue_idx_q <= '0;
				chk_s1 <= 1'b0;
				cnt_q <= '0;
				pend_valid_q <= 1'b0;
			end else if (scan_go) begin
				chk_s1 <= issue;
				if (issue) begin
					issue_idx_q <= issue_idx_q + (IDX_W + 1)'(1);
				end
				if (hit_wake) begin
					cnt_q <= cnt_next;
					pend_valid_q <= 1'b1;
				end
			end
			if (load_mid || load_fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			is_wake_q <= (command == CMD_WAKE);
			addr_q <= address;
			task_q <= task_id;
			limit_q <= argument_value[VALUE_WIDTH-1] ? '0 : argument_value;
			if (command == CMD_WAIT) begin
				if (load_fault) begin
					res_status_q <= ST_FAULT;
				end else if (loaded_value != argument_value) begin
					res_status_q <= ST_AGAIN;
				end else begin
					res_status_q <= ST_NO_SPACE;
				end
			end else if (command == CMD_WAKE) begin
				res_status_q <= ST_WAKE_DONE;
			end else begin
				res_status_q <= ST_UNSUPPORTED;
			end
		end else if (hit_free) begin
			res_status_q <= ST_BLOCKED;
		end
		if (scan_go) begin
			chk_idx_s1 <= issue_idx_q[IDX_W-1:0];
		end
		if (hit_wake) begin
			pend_task_q <= entry_task;
		end
		if (load_mid) begin
			out_status_q <= ST_WAKE_DONE;
			out_task_q <= pend_task_q;
			out_wvalid_q <= 1'b1;
			out_total_q <= '0;
			out_last_q <= 1'b0;
		end else if (load_fin) begin
			out_status_q <= res_status_q;
			out_task_q <= pend_valid_q ? pend_task_q : '0;
			out_wvalid_q <= pend_valid_q;
			out_total_q <= TOTAL_WIDTH'(cnt_q);
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign woken_task = out_task_q;
	assign woken_valid = out_wvalid_q;
	assign woken_total = out_total_q;
	assign last = out_last_q;

	// Only wake results can be followed by more results of the same request.
	a_mid_is_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> woken_valid && status == ST_WAKE_DONE)
		else $error("non-final result that is not a woken task");

	a_total_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && woken_total != '0 |-> last && woken_valid)
		else $error("wake total on a result that is not the last woken one");

	a_wake_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hit_wake |-> VALUE_WIDTH'(cnt_q) < limit_q)
		else $error("wake released more tasks than its count");

	a_write_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && state_q != SQ_CLEAR |-> state_q == SQ_SCAN && chk_s1)
		else $error("table written outside a slot check");

	a_mid_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		load_mid |-> out_free && is_wake_q)
		else $error("woken task moved out while the output was busy");

endmodule
`default_nettype wire

@@ tb/futex_wait_wake_table_unit_tb.sv @@
// Self-checking testbench for the futex wait/wake table: random and directed requests, scoreboard.
`timescale 1ns / 100ps
module futex_wait_wake_table_unit_tb;
	import fwwt_pkg::*;

	localparam int DEPTH = 64;
	localparam int TID_W = 8;
	localparam int ADDR_W = 48;
	localparam logic [1:0] CMD_OTHER_A = 2'd2;
	localparam logic [1:0] CMD_OTHER_B = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		status_t status;
		logic [TID_W-1:0] woken_task;
		logic woken_valid;
		logic [TOTAL_WIDTH-1:0] woken_total;
		logic last;
	} wake_result_t;

	class wait_table_scoreboard;
		logic [ADDR_W-1:0] slot_addr [DEPTH];
		logic [TID_W-1:0] slot_tid [DEPTH];
		bit slot_busy [DEPTH];
		wake_result_t expected_q [$];
		int errors;

		function new();
			errors = 0;
			foreach (slot_busy[i]) slot_busy[i] = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_single(status_t s);
			wake_result_t r;
			r = '0;
			r.status = s;
			r.last = 1'b1;
			expected_q.push_back(r);
		endfunction

		// Updates the table copy for one accepted request and queues its results.
		function void note_request(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
				logic [31:0] arg, logic [31:0] ld, logic flt, logic [TID_W-1:0] tid);
			wake_result_t held;
			logic [31:0] limit;
			int unsigned woken;
			bit placed;
			held = '0;
			woken = 0;
			placed = 1'b0;
			case (cmd)
				CMD_WAIT: begin
					if (flt)
						push_single(ST_FAULT);
					else if (ld != arg)
						push_single(ST_AGAIN);
					else begin
						for (int i = 0; i < DEPTH && !placed; i++) begin
							if (!slot_busy[i]) begin
								slot_busy[i] = 1'b1;
								slot_addr[i] = addr;
								slot_tid[i] = tid;
								placed = 1'b1;
							end
						end
						push_single(placed ? ST_BLOCKED : ST_NO_SPACE);
					end
				end
				CMD_WAKE: begin
					// A count with the sign bit set wakes nobody.
					limit = arg[31] ? 32'd0 : arg;
					for (int i = 0; i < DEPTH && woken < limit; i++) begin
						if (slot_busy[i] && slot_addr[i] == addr) begin
							slot_busy[i] = 1'b0;
							if (woken != 0) expected_q.push_back(held);
							held = '0;
							held.status = ST_WAKE_DONE;
							held.woken_task = slot_tid[i];
							held.woken_valid = 1'b1;
							woken++;
						end
					end
					if (woken == 0)
						push_single(ST_WAKE_DONE);
					else begin
						held.woken_total = woken[TOTAL_WIDTH-1:0];
						held.last = 1'b1;
						expected_q.push_back(held);
					end
				end
				default: push_single(ST_UNSUPPORTED);
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
			end
		endfunction

		function void check_result(wake_result_t got);
			wake_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d task %0d last %0d",
					$time, got.status, got.woken_task, got.last);
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("woken_task", want.woken_task, got.woken_task);
			compare_field("woken_valid", 8'(want.woken_valid), 8'(got.woken_valid));
			compare_field("woken_total", 8'(want.woken_total), 8'(got.woken_total));
			compare_field("last", 8'(want.last), 8'(got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] command;
	logic [ADDR_W-1:0] address;
	logic [VALUE_WIDTH-1:0] argument_value;
	logic [VALUE_WIDTH-1:0] loaded_value;
	logic load_fault;
	logic [TID_W-1:0] task_id;
	logic out_valid;
	logic out_stall;
	logic [STATUS_WIDTH-1:0] status;
	logic [TID_W-1:0] woken_task;
	logic woken_valid;
	logic [TOTAL_WIDTH-1:0] woken_total;
	logic last;

	bit calm;
	int hold_req;
	logic [ADDR_W-1:0] addr_pool [4];
	wait_table_scoreboard sb = new();

	futex_wait_wake_table_unit #(
		.TABLE_DEPTH(DEPTH),
		.TASK_ID_WIDTH(TID_W),
		.ADDRESS_WIDTH(ADDR_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.address(address),
		.argument_value(argument_value),
		.loaded_value(loaded_value),
		.load_fault(load_fault),
		.task_id(task_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.woken_task(woken_task),
		.woken_valid(woken_valid),
		.woken_total(woken_total),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function logic [ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	// Called just after a rising edge; returns at the edge that accepts the request.
	task send_request(logic [1:0] cmd, logic [ADDR_W-1:0] addr, logic [31:0] arg,
			logic [31:0] ld, logic flt, logic [TID_W-1:0] tid);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		command = cmd;
		address = addr;
		argument_value = arg;
		loaded_value = ld;
		load_fault = flt;
		task_id = tid;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_request(cmd, addr, arg, ld, flt, tid);
	endtask

	task send_random(int wait_pct, int pool_n);
		logic [ADDR_W-1:0] addr;
		logic [31:0] arg;
		logic [31:0] ld;
		int r;
		int k;
		addr = ($urandom_range(0, 9) == 0) ? rand_addr() : addr_pool[$urandom_range(0, pool_n - 1)];
		r = $urandom_range(0, 99);
		if (r < wait_pct) begin
			arg = $urandom;
			k = $urandom_range(0, 99);
			ld = (k < 8) ? ~arg : arg;
			send_request(CMD_WAIT, addr, arg, ld, k >= 8 && k < 16, TID_W'($urandom));
		end else if (r < 95) begin
			k = $urandom_range(0, 9);
			if (k < 6)
				arg = $urandom_range(1, 4);
			else if (k == 6)
				arg = 32'd0;
			else if (k == 7)
				arg = 32'h8000_0000 | $urandom;
			else if (k == 8)
				arg = $urandom_range(5, 70);
			else
				arg = 32'h7fff_ffff;
			send_request(CMD_WAKE, addr, arg, $urandom, 1'($urandom_range(0, 1)),
				TID_W'($urandom));
		end else begin
			send_request($urandom_range(0, 1) ? CMD_OTHER_A : CMD_OTHER_B, addr, $urandom,
				$urandom, 1'($urandom_range(0, 1)), TID_W'($urandom));
		end
	endtask

	// Receiving side: random stall bursts, one long hold-off on request, none when calm.
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				out_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 15) - 1) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		wake_result_t got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.status = status_t'(status);
			got.woken_task = woken_task;
			got.woken_valid = woken_valid;
			got.woken_total = woken_total;
			got.last = last;
			sb.check_result(got);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("futex_wait_wake_table_unit_tb: done, errors");
		$finish;
	end

	initial begin
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
		logic [31:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_WAIT;
		address = '0;
		argument_value = '0;
		loaded_value = '0;
		load_fault = 1'b0;
		task_id = '0;
		calm = 1'b0;
		hold_req = 0;
		addr_a = rand_addr();
		addr_b = ~addr_a;
		v = $urandom;
		addr_pool[0] = rand_addr();
		addr_pool[1] = rand_addr();
		addr_pool[2] = '0;
		addr_pool[3] = '1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed requests: empty table, precedence of fault over mismatch, extremes.
		send_request(CMD_WAKE, addr_a, 32'd1, $urandom, 1'b1, TID_W'($urandom));
		send_request(CMD_WAIT, addr_a, '1, '1, 1'b1, 8'h5a);
		send_request(CMD_WAIT, addr_a, 32'd0, 32'd1, 1'b0, 8'ha5);
		send_request(CMD_WAIT, addr_a, 32'd0, '1, 1'b1, 8'h11);
		send_request(CMD_WAIT, '1, 32'h1234_5678, 32'h1234_5678, 1'b0, 8'hff);
		send_request(CMD_WAIT, '0, 32'd0, 32'd0, 1'b0, 8'h00);
		send_request(CMD_WAIT, addr_a, v, v, 1'b0, 8'd1);
		send_request(CMD_WAIT, addr_a, v, v, 1'b0, 8'd2);
		send_request(CMD_WAIT, addr_a, v, v, 1'b0, 8'd3);
		send_request(CMD_OTHER_A, '1, '1, '1, 1'b1, '1);
		send_request(CMD_OTHER_B, '0, '0, '0, 1'b0, '0);
		send_request(CMD_WAKE, addr_a, 32'd0, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, addr_a, 32'h8000_0000, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, addr_a, 32'hffff_ffff, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, addr_b, 32'd5, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, addr_a, 32'd2, $urandom, 1'b0, TID_W'($urandom));
		// The freed lowest slot is reused, so index order differs from arrival order.
		send_request(CMD_WAIT, addr_a, ~v, ~v, 1'b0, 8'd4);
		send_request(CMD_WAKE, addr_a, 32'h7fff_ffff, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, '0, 32'd1, $urandom, 1'b1, TID_W'($urandom));
		send_request(CMD_WAKE, '1, 32'd64, $urandom, 1'b1, TID_W'($urandom));

		repeat (70) send_random(55, 4);

		// Fill the table past full on two addresses while the output is held off.
		hold_req = HOLD_OFF_CYCLES;
		repeat (70) send_random(100, 2);
		send_request(CMD_WAKE, addr_pool[0], 32'h7fff_ffff, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, addr_pool[1], 32'd64, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, addr_pool[0], 32'd64, $urandom, 1'b0, TID_W'($urandom));
		send_request(CMD_WAKE, addr_pool[1], 32'h7fff_ffff, $urandom, 1'b0, TID_W'($urandom));

		// Let every outstanding result drain before the next request.
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		calm = 1'b1;
		repeat (50) send_random(55, 4);

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d results still expected, actual none", $time, sb.pending());
		end
		if (sb.errors == 0)
			$display("futex_wait_wake_table_unit_tb: done, clean");
		else
			$display("futex_wait_wake_table_unit_tb: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/fwwt_pkg.sv
rtl/core/fwwt_table.sv
rtl/core/futex_wait_wake_table_unit.sv
tb/futex_wait_wake_table_unit_tb.sv
